>>> hdl/fjgu_pkg.sv
// Types, codes and fixed-point helpers for the full Jones gain update block.
// Used by fjgu_div, full_jones_gain_update_top, fjgu_checker and tb; depends on nothing else.
package fjgu_pkg;

    // Q8.24 one
    localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;

    // Function codes of an input item
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_ACC   = 2'd1;
    localparam logic [1:0] FUNC_SOLVE = 2'd2;

    // Restoring divider: quotient bits of floor(a * 2^48 / m)
    localparam int DIV_STEPS = 80;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } cx_t;

    // Element 0 is xx, then xy, yx, yy
    typedef cx_t [3:0] mat_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [6:0]  other_antenna;
        logic [4:0]  channel;
        logic [63:0] vis_xx;
        logic [63:0] vis_xy;
        logic [63:0] vis_yx;
        logic [63:0] vis_yy;
        logic [63:0] model_xx;
        logic [63:0] model_xy;
        logic [63:0] model_yx;
        logic [63:0] model_yy;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  channel_out;
        logic [63:0] gain_xx;
        logic [63:0] gain_xy;
        logic [63:0] gain_yx;
        logic [63:0] gain_yy;
        logic        singular;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_DIV,
        ST_DONE
    } state_t;

    // Matrix phases run on the shared complex multiplier
    typedef enum logic [2:0] {
        OP_A,
        OP_NUM,
        OP_DEN,
        OP_DET,
        OP_MAG,
        OP_T,
        OP_G
    } op_t;

    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        op_t        op;
        logic [1:0] k;
    } mac_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        if (v > 44'sd2147483647)
            return 32'sh7fff_ffff;
        else if (v < -44'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // Round a Q16.48 product to Q8.24: add half, floor shift
    function automatic logic signed [39:0] rnd24(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd8388608;
        return s[63:24];
    endfunction

    function automatic cx_t conjs(input cx_t c);
        cx_t r;
        r.re = c.re;
        r.im = sat32(-44'(c.im));
        return r;
    endfunction

    function automatic cx_t negs(input cx_t c);
        cx_t r;
        r.re = sat32(-44'(c.re));
        r.im = sat32(-44'(c.im));
        return r;
    endfunction

    function automatic cx_t cx_add_sat(input cx_t a, input cx_t b);
        cx_t r;
        r.re = sat32(44'(a.re) + 44'(b.re));
        r.im = sat32(44'(a.im) + 44'(b.im));
        return r;
    endfunction

    function automatic mat_t mat_herm(input mat_t x);
        mat_t z;
        z[0] = conjs(x[0]);
        z[1] = conjs(x[2]);
        z[2] = conjs(x[1]);
        z[3] = conjs(x[3]);
        return z;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = v[31] ? -33'(v) : 33'(v);
        return w[31:0];
    endfunction

    // Apply sign to a quotient magnitude and saturate to Q8.24
    function automatic logic signed [31:0] vsat(input logic neg, input logic [79:0] q);
        if (q > 80'd2147483647)
            return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            return neg ? -$signed(q[31:0]) : $signed(q[31:0]);
    endfunction

    localparam cx_t  CX_ONE    = '{re: Q_ONE, im: 32'sd0};
    localparam cx_t  CX_ZERO   = '{re: 32'sd0, im: 32'sd0};
    localparam mat_t MAT_IDENT = {CX_ONE, CX_ZERO, CX_ZERO, CX_ONE};

endpackage

>>> hdl/full_jones_gain_update_top.sv
// A load is written to the gain table as it is accepted; an accumulate reads the tables,
// runs three matrix phases on the shared complex multiplier and writes the sums back;
// a solve runs two passes of the bit-serial divider plus four matrix phases.
// One item at a time: the next item is taken once the current one is written back.
// Reset: async, active low; then a clearing pass over all ANTENNAS*CHANNELS rows
// (4096 by default) sets the gain table to identity and the sums to zero.
module full_jones_gain_update_top #(
    parameter int ANTENNAS = 128,
    parameter int CHANNELS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  fjgu_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output fjgu_pkg::out_item_t out_data
);
    import fjgu_pkg::*;

    localparam int ROWS  = ANTENNAS * CHANNELS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Control state
    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [3:0]       step_reg, step_next;
    logic             div_im_reg, div_im_next;
    logic             singular_reg, singular_next;
    logic [ROW_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [6:0]       target_reg;
    logic             out_valid_reg;
    mac_ctl_t         mac_ctl_reg;

    // Item payload and working matrices
    logic             solve_reg;
    logic [4:0]       channel_reg;
    mat_t             gain_rd_reg, num_rd_reg, den_rd_reg;
    mat_t             d_reg, m_reg, a_reg, num_reg, den_reg;
    cx_t              det_reg, v_reg;
    logic [63:0]      m2_reg;
    logic signed [63:0] prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [43:0] acc_re_reg, acc_im_reg;
    out_item_t        out_reg;

    // Memories
    mat_t gain_mem [ROWS];
    mat_t num_mem  [CHANNELS];
    mat_t den_mem  [CHANNELS];

    logic             accept, item_go, load_wr, ch_ok, ant_ok, tgt_ok, flip;
    logic             clearing, out_load, div_start, div_done, mac_issue;
    logic [ROW_W-1:0] load_row, rd_row, gain_wa;
    mat_t             gain_wd, d_in, m_in, sums_wd_num, sums_wd_den;
    logic [CH_W-1:0]  in_ch_idx, ch_idx, sums_wa;
    logic             sums_we;
    logic [6:0]       rd_ant;
    logic [3:0]       issue_cnt;
    logic [1:0]       k_sel;
    logic             t_sel, first_sel, last_sel;
    cx_t              x_op, y_op, mac_res;
    logic signed [43:0] pre, pim, sum_re, sum_im;
    logic [63:0]      m2_val;
    logic [31:0]      div_a;
    logic [79:0]      div_q;
    logic             det_zero;

    // Input decode and filtering
    assign accept    = in_valid && !in_stall;
    assign ch_ok     = 32'(in_data.channel) < CHANNELS;
    assign ant_ok    = 32'(in_data.other_antenna) < ANTENNAS;
    assign tgt_ok    = 32'(target_reg) < ANTENNAS;
    assign flip      = target_reg > in_data.other_antenna;
    assign item_go   = ch_ok && ((in_data.func == FUNC_SOLVE) ||
                       (in_data.func == FUNC_ACC && ant_ok &&
                        in_data.other_antenna != target_reg));
    assign load_wr   = accept && ch_ok && ant_ok && in_data.func == FUNC_LOAD;
    assign in_ch_idx = CH_W'(32'(in_data.channel));
    assign ch_idx    = CH_W'(32'(channel_reg));
    assign rd_ant    = (in_data.func == FUNC_SOLVE) ? (tgt_ok ? target_reg : 7'd0)
                                                   : in_data.other_antenna;
    assign load_row  = ROW_W'(32'(in_data.other_antenna) * CHANNELS + 32'(in_data.channel));
    assign rd_row    = ROW_W'(32'(rd_ant) * CHANNELS + 32'(in_data.channel));
    assign clearing  = state_reg == ST_CLEAR;
    assign in_stall  = state_reg != ST_IDLE;

    always_comb
    begin
        d_in = {cx_t'(in_data.vis_yy), cx_t'(in_data.vis_yx),
                cx_t'(in_data.vis_xy), cx_t'(in_data.vis_xx)};
        m_in = {cx_t'(in_data.model_yy), cx_t'(in_data.model_yx),
                cx_t'(in_data.model_xy), cx_t'(in_data.model_xx)};
    end

    // Gain table: clearing pass or load write, read on accepted item
    assign gain_wa = clearing ? clr_cnt_reg : load_row;
    assign gain_wd = clearing ? MAT_IDENT : d_in;

    always_ff @(posedge clk)
    begin
        if (clearing || load_wr)
            gain_mem[gain_wa] <= gain_wd;
        if (accept && item_go)
            gain_rd_reg <= gain_mem[rd_row];
    end

    // Sum memories: zero on clear and after solve, write back after accumulate
    assign sums_we     = (clearing && 32'(clr_cnt_reg) < CHANNELS) || state_reg == ST_DONE;
    assign sums_wa     = clearing ? CH_W'(clr_cnt_reg) : ch_idx;
    assign sums_wd_num = (clearing || solve_reg) ? '0 : num_reg;
    assign sums_wd_den = (clearing || solve_reg) ? '0 : den_reg;

    always_ff @(posedge clk)
    begin
        if (sums_we)
        begin
            num_mem[sums_wa] <= sums_wd_num;
            den_mem[sums_wa] <= sums_wd_den;
        end
        if (accept && item_go)
        begin
            num_rd_reg <= num_mem[in_ch_idx];
            den_rd_reg <= den_mem[in_ch_idx];
        end
    end

    // Phase length and element/term of the current step
    always_comb
    begin
        unique case (op_reg)
            OP_A, OP_NUM, OP_DEN, OP_G:
            begin
                issue_cnt = 4'd8;
                k_sel     = step_reg[2:1];
                t_sel     = step_reg[0];
                last_sel  = step_reg[0];
            end
            OP_T:
            begin
                issue_cnt = 4'd4;
                k_sel     = step_reg[1:0];
                t_sel     = 1'b0;
                last_sel  = 1'b1;
            end
            OP_DET:
            begin
                issue_cnt = 4'd2;
                k_sel     = 2'd0;
                t_sel     = step_reg[0];
                last_sel  = step_reg[0];
            end
            OP_MAG:
            begin
                issue_cnt = 4'd1;
                k_sel     = 2'd0;
                t_sel     = 1'b0;
                last_sel  = 1'b1;
            end
            default:
            begin
                issue_cnt = 4'd0;
                k_sel     = 2'd0;
                t_sel     = 1'b0;
                last_sel  = 1'b1;
            end
        endcase
        first_sel = !t_sel;
        mac_issue = state_reg == ST_MAC && step_reg != issue_cnt;
    end

    // Operand select: in the matrix products x is row k[1], term t; y is term t, column k[0]
    always_comb
    begin
        unique case (op_reg)
            OP_A:
            begin
                x_op = gain_rd_reg[{k_sel[1], t_sel}];
                y_op = d_reg[{t_sel, k_sel[0]}];
            end
            OP_NUM:
            begin
                x_op = m_reg[{k_sel[1], t_sel}];
                y_op = a_reg[{t_sel, k_sel[0]}];
            end
            OP_DEN:
            begin
                x_op = conjs(a_reg[{t_sel, k_sel[1]}]);
                y_op = a_reg[{t_sel, k_sel[0]}];
            end
            OP_DET:
            begin
                x_op = t_sel ? negs(den_reg[1]) : den_reg[0];
                y_op = t_sel ? den_reg[2] : den_reg[3];
            end
            OP_MAG:
            begin
                x_op = det_reg;
                y_op = det_reg;
            end
            OP_T:
            begin
                unique case (k_sel)
                    2'd0:    x_op = den_reg[3];
                    2'd1:    x_op = negs(den_reg[1]);
                    2'd2:    x_op = negs(den_reg[2]);
                    default: x_op = den_reg[0];
                endcase
                y_op = v_reg;
            end
            OP_G:
            begin
                x_op = num_reg[{k_sel[1], t_sel}];
                y_op = a_reg[{t_sel, k_sel[0]}];
            end
            default:
            begin
                x_op = CX_ZERO;
                y_op = CX_ZERO;
            end
        endcase
    end

    // Shared complex multiplier: four real products, registered
    always_ff @(posedge clk)
    begin
        prr_reg <= x_op.re * y_op.re;
        pii_reg <= x_op.im * y_op.im;
        pri_reg <= x_op.re * y_op.im;
        pir_reg <= x_op.im * y_op.re;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mac_ctl_reg <= '0;
        else
            mac_ctl_reg <= '{valid: mac_issue, first: first_sel, last: last_sel,
                             op: op_reg, k: k_sel};
    end

    // Round, combine and accumulate the terms of one element
    always_comb
    begin
        pre     = 44'(rnd24(prr_reg)) - 44'(rnd24(pii_reg));
        pim     = 44'(rnd24(pri_reg)) + 44'(rnd24(pir_reg));
        sum_re  = (mac_ctl_reg.first ? 44'sd0 : acc_re_reg) + pre;
        sum_im  = (mac_ctl_reg.first ? 44'sd0 : acc_im_reg) + pim;
        mac_res = '{re: sat32(sum_re), im: sat32(sum_im)};
        m2_val  = 64'(prr_reg) + 64'(pii_reg);
        det_zero = det_reg.re == 32'sd0 && det_reg.im == 32'sd0;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        step_next     = step_reg;
        div_im_next   = div_im_reg;
        singular_next = singular_reg;
        clr_cnt_next  = clr_cnt_reg;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_W'(ROWS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept && item_go)
                begin
                    state_next    = ST_READ;
                    singular_next = 1'b0;
                end
            end
            ST_READ:
            begin
                state_next = ST_MAC;
                op_next    = solve_reg ? OP_DET : OP_A;
                step_next  = 4'd0;
            end
            ST_MAC:
            begin
                if (step_reg == issue_cnt)
                begin
                    step_next = 4'd0;
                    unique case (op_reg)
                        OP_A:   op_next = OP_NUM;
                        OP_NUM: op_next = OP_DEN;
                        OP_DET: op_next = OP_MAG;
                        OP_T:   op_next = OP_G;
                        OP_MAG:
                        begin
                            if (det_zero)
                            begin
                                singular_next = 1'b1;
                                state_next    = ST_DONE;
                            end
                            else
                            begin
                                state_next  = ST_DIV;
                                div_im_next = 1'b0;
                                div_start   = 1'b1;
                            end
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (!div_im_reg)
                    begin
                        div_im_next = 1'b1;
                        div_start   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_MAC;
                        op_next    = OP_T;
                        step_next  = 4'd0;
                    end
                end
            end
            ST_DONE:
            begin
                if (!solve_reg)
                    state_next = ST_IDLE;
                else if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            op_reg       <= OP_A;
            step_reg     <= '0;
            div_im_reg   <= 1'b0;
            singular_reg <= 1'b0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            step_reg     <= step_next;
            div_im_reg   <= div_im_next;
            singular_reg <= singular_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= '0;
        else if (cfg_wr_en)
            target_reg <= cfg_wr_data;
    end

    // Inverse scale: divide each determinant part by |det|^2
    assign div_a = div_im_next ? mag32(det_reg.im) : mag32(det_reg.re);

    fjgu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (m2_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Working registers: capture item, load sums, write back phase results
    always_ff @(posedge clk)
    begin
        if (accept && item_go)
        begin
            solve_reg   <= in_data.func == FUNC_SOLVE;
            channel_reg <= in_data.channel;
            d_reg       <= flip ? d_in : mat_herm(d_in);
            m_reg       <= flip ? mat_herm(m_in) : m_in;
        end
        if (state_reg == ST_READ)
        begin
            num_reg <= num_rd_reg;
            den_reg <= den_rd_reg;
        end
        if (mac_ctl_reg.valid)
        begin
            acc_re_reg <= sum_re;
            acc_im_reg <= sum_im;
            if (mac_ctl_reg.last)
            begin
                unique case (mac_ctl_reg.op)
                    OP_A, OP_T: a_reg[mac_ctl_reg.k] <= mac_res;
                    OP_NUM: num_reg[mac_ctl_reg.k] <= cx_add_sat(num_reg[mac_ctl_reg.k], mac_res);
                    OP_DEN: den_reg[mac_ctl_reg.k] <= cx_add_sat(den_reg[mac_ctl_reg.k], mac_res);
                    OP_DET: det_reg <= mac_res;
                    OP_MAG: m2_reg <= m2_val;
                    OP_G:   m_reg[mac_ctl_reg.k] <= mac_res;
                    default: ;
                endcase
            end
        end
        if (div_done)
        begin
            if (!div_im_reg)
                v_reg.re <= vsat(det_reg.re[31], div_q);
            else
                v_reg.im <= vsat(!det_reg.im[31], div_q);
        end
    end

    // Output register: hold until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.channel_out <= channel_reg;
            out_reg.singular    <= singular_reg;
            if (singular_reg)
            begin
                out_reg.gain_xx <= tgt_ok ? gain_rd_reg[0] : MAT_IDENT[0];
                out_reg.gain_xy <= tgt_ok ? gain_rd_reg[1] : MAT_IDENT[1];
                out_reg.gain_yx <= tgt_ok ? gain_rd_reg[2] : MAT_IDENT[2];
                out_reg.gain_yy <= tgt_ok ? gain_rd_reg[3] : MAT_IDENT[3];
            end
            else
            begin
                out_reg.gain_xx <= m_reg[0];
                out_reg.gain_xy <= m_reg[1];
                out_reg.gain_yx <= m_reg[2];
                out_reg.gain_yy <= m_reg[3];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Multiplier results only arrive while a matrix phase runs
    a_mac_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctl_reg.valid |-> state_reg == ST_MAC)
        else $error("multiplier result outside a matrix phase");

    // Divider completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    // Only a solve item produces a result
    a_out_from_solve: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> solve_reg)
        else $error("result emitted for a non-solve item");

    // A started item blocks the input on the next cycle
    a_busy_after_go: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_go) |=> in_stall)
        else $error("input not held while an item is in work");

endmodule

>>> hdl/fjgu_div.sv
// Bit-serial restoring divider: floor(dividend * 2^48 / divisor), one bit a cycle.
// Depends on fjgu_pkg for the step count.
module fjgu_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [79:0] quotient
);
    import fjgu_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [79:0] sh_reg;
    logic [64:0] rem_reg;
    logic [79:0] quo_reg;
    logic [64:0] trial;
    logic [64:0] rem_next;
    logic        ge;

    // Shift in one dividend bit and try the subtraction
    always_comb
    begin
        trial    = {rem_reg[63:0], sh_reg[79]};
        ge       = trial >= {1'b0, divisor};
        rem_next = ge ? trial - {1'b0, divisor} : trial;
    end

    // Control: step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            if (cnt_reg == 7'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= {dividend, 48'd0};
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[78:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[78:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> dv/fjgu_checker.sv
// Checker for the full Jones gain update block: watches the register port and both
// channels, predicts each solve result and compares it with the block's output.
// Depends on fjgu_pkg for the payload and complex types.
`timescale 1ns / 1ps

module fjgu_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  fjgu_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  fjgu_pkg::out_item_t out_data,
    output int                  fail_count,
    output int                  pending
);
    import fjgu_pkg::cx_t;
    import fjgu_pkg::mat_t;
    import fjgu_pkg::in_item_t;
    import fjgu_pkg::out_item_t;
    import fjgu_pkg::FUNC_LOAD;
    import fjgu_pkg::FUNC_ACC;
    import fjgu_pkg::FUNC_SOLVE;

    localparam int NUM_ANT = 128;
    localparam int NUM_CH  = 32;
    localparam logic [63:0] ONE_PACKED = 64'h0100_0000_0000_0000;

    // Predictor state
    mat_t       gain_tbl [NUM_ANT][NUM_CH];
    mat_t       num_sum  [NUM_CH];
    mat_t       den_sum  [NUM_CH];
    logic [6:0] target;
    out_item_t  gain_q [$];

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Q8.24 real product, rounded half up by floor shift
    function automatic longint qmul(input logic signed [31:0] a, input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd8388608;
        return p >>> 24;
    endfunction

    function automatic cx_t cdot(input cx_t a, input cx_t b, input cx_t c, input cx_t d);
        cx_t r;
        r.re = clip32(qmul(a.re, b.re) - qmul(a.im, b.im) + qmul(c.re, d.re) - qmul(c.im, d.im));
        r.im = clip32(qmul(a.re, b.im) + qmul(a.im, b.re) + qmul(c.re, d.im) + qmul(c.im, d.re));
        return r;
    endfunction

    function automatic cx_t cconj(input cx_t a);
        cx_t r;
        r.re = a.re;
        r.im = clip32(-longint'(a.im));
        return r;
    endfunction

    function automatic cx_t cneg(input cx_t a);
        cx_t r;
        r.re = clip32(-longint'(a.re));
        r.im = clip32(-longint'(a.im));
        return r;
    endfunction

    function automatic mat_t mmul(input mat_t x, input mat_t y);
        mat_t z;
        z[0] = cdot(x[0], y[0], x[1], y[2]);
        z[1] = cdot(x[0], y[1], x[1], y[3]);
        z[2] = cdot(x[2], y[0], x[3], y[2]);
        z[3] = cdot(x[2], y[1], x[3], y[3]);
        return z;
    endfunction

    function automatic mat_t mherm(input mat_t x);
        mat_t z;
        z[0] = cconj(x[0]);
        z[1] = cconj(x[2]);
        z[2] = cconj(x[1]);
        z[3] = cconj(x[3]);
        return z;
    endfunction

    function automatic mat_t madd(input mat_t s, input mat_t p);
        mat_t z;
        for (int i = 0; i < 4; i++) begin
            z[i].re = clip32(longint'(s[i].re) + longint'(p[i].re));
            z[i].im = clip32(longint'(s[i].im) + longint'(p[i].im));
        end
        return z;
    endfunction

    // floor(|p| * 2^48 / m2)
    function automatic longint inv_part(input logic signed [31:0] p,
                                        input logic [63:0] m2);
        logic [127:0] num;
        logic [127:0] q;
        num = 128'(p[31] ? -longint'(p) : longint'(p)) << 48;
        q = num / 128'(m2);
        return longint'(q[63:0]);
    endfunction

    task automatic clear_model();
        mat_t ident;
        mat_t zero;
        ident = {64'(ONE_PACKED), 64'd0, 64'd0, 64'(ONE_PACKED)};
        zero = '0;
        for (int a = 0; a < NUM_ANT; a++)
            for (int c = 0; c < NUM_CH; c++)
                gain_tbl[a][c] = ident;
        for (int c = 0; c < NUM_CH; c++) begin
            num_sum[c] = zero;
            den_sum[c] = zero;
        end
        target = '0;
    endtask

    // Advance the model by one accepted item; queue a result for a solve
    task automatic predict_item(input in_item_t it);
        mat_t j, d, m, a, p, r, t, g;
        cx_t det, v, z;
        logic [63:0] m2;
        longint qr, qi;
        out_item_t res;
        int ch, oth;
        ch = it.channel;
        oth = it.other_antenna;
        d = {it.vis_yy, it.vis_yx, it.vis_xy, it.vis_xx};
        m = {it.model_yy, it.model_yx, it.model_xy, it.model_xx};
        case (it.func)
            FUNC_LOAD:
                gain_tbl[oth][ch] = d;
            FUNC_ACC:
            begin
                if (oth != int'(target)) begin
                    j = gain_tbl[oth][ch];
                    if (target > it.other_antenna) begin
                        a = mmul(j, d);
                        p = mmul(mherm(m), a);
                    end
                    else begin
                        a = mmul(j, mherm(d));
                        p = mmul(m, a);
                    end
                    num_sum[ch] = madd(num_sum[ch], p);
                    den_sum[ch] = madd(den_sum[ch], mmul(mherm(a), a));
                end
            end
            FUNC_SOLVE:
            begin
                r = den_sum[ch];
                det = cdot(r[0], r[3], cneg(r[1]), r[2]);
                res.channel_out = it.channel;
                if (det.re == 0 && det.im == 0) begin
                    g = gain_tbl[target][ch];
                    res.singular = 1'b1;
                end
                else begin
                    m2 = 64'(longint'(det.re) * longint'(det.re))
                       + 64'(longint'(det.im) * longint'(det.im));
                    qr = inv_part(det.re, m2);
                    qi = inv_part(det.im, m2);
                    v.re = clip32(det.re < 0 ? -qr : qr);
                    v.im = clip32(det.im < 0 ? qi : -qi);
                    z = '0;
                    t[0] = cdot(r[3], v, z, z);
                    t[1] = cdot(cneg(r[1]), v, z, z);
                    t[2] = cdot(cneg(r[2]), v, z, z);
                    t[3] = cdot(r[0], v, z, z);
                    g = mmul(num_sum[ch], t);
                    res.singular = 1'b0;
                end
                res.gain_xx = g[0];
                res.gain_xy = g[1];
                res.gain_yx = g[2];
                res.gain_yy = g[3];
                gain_q.push_back(res);
                num_sum[ch] = '0;
                den_sum[ch] = '0;
            end
            default:
                ;
        endcase
    endtask

    task automatic report(input string field, input logic [63:0] exp_v, input logic [63:0] got);
        if (exp_v !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %h, got %h at %0t", field, exp_v, got, $realtime);
        end
    endtask

    // Compare output transfers, then fold in input transfers and register writes
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n) begin
            clear_model();
            gain_q.delete();
        end
        else begin
            if (out_valid && !out_stall) begin
                if (gain_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer at %0t", $realtime);
                end
                else begin
                    e = gain_q.pop_front();
                    report("channel_out", 64'(e.channel_out), 64'(out_data.channel_out));
                    report("gain_xx", e.gain_xx, out_data.gain_xx);
                    report("gain_xy", e.gain_xy, out_data.gain_xy);
                    report("gain_yx", e.gain_yx, out_data.gain_yx);
                    report("gain_yy", e.gain_yy, out_data.gain_yy);
                    report("singular", 64'(e.singular), 64'(out_data.singular));
                end
            end
            if (in_valid && !in_stall)
                predict_item(in_data);
            if (cfg_wr_en)
                target = cfg_wr_data;
        end
        pending = gain_q.size();
    end

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

endmodule

>>> dv/tb.sv
// Testbench top for full_jones_gain_update_top: clock, reset, register writes,
// directed and random item streams, random stalls and the final verdict.
// Depends on fjgu_pkg, the block and fjgu_checker.
`timescale 1ns / 1ps

module tb;
    import fjgu_pkg::in_item_t;
    import fjgu_pkg::out_item_t;
    import fjgu_pkg::FUNC_LOAD;
    import fjgu_pkg::FUNC_ACC;
    import fjgu_pkg::FUNC_SOLVE;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 250;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [6:0] cfg_wr_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       gaps_on = 1'b1;
    int         fail_count;
    int         pending;
    int         cycles = 0;
    logic [6:0] target = '0;

    full_jones_gain_update_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    fjgu_checker chk (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One complex value: mostly near unit scale, some full range, some corners
    function automatic logic [63:0] cx_val(input int kind);
        logic [31:0] corner [4];
        corner[0] = 32'h7fff_ffff;
        corner[1] = 32'h8000_0000;
        corner[2] = 32'h0000_0000;
        corner[3] = 32'h0100_0000;
        case (kind)
            0: return {32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000,
                       32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000};
            1: return {$urandom, $urandom};
            default: return {corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)]};
        endcase
    endfunction

    function automatic int pick_kind();
        int r;
        r = $urandom_range(0, 9);
        return r < 8 ? 0 : (r == 8 ? 1 : 2);
    endfunction

    function automatic in_item_t make_item(input logic [1:0] f, input int oth, input int ch,
                                           input int kind);
        in_item_t it;
        it.func = f;
        it.other_antenna = 7'(oth);
        it.channel = 5'(ch);
        it.vis_xx = cx_val(kind);
        it.vis_xy = cx_val(kind);
        it.vis_yx = cx_val(kind);
        it.vis_yy = cx_val(kind);
        it.model_xx = cx_val(kind);
        it.model_xy = cx_val(kind);
        it.model_yx = cx_val(kind);
        it.model_yy = cx_val(kind);
        return it;
    endfunction

    // Present one item after a random gap and hold it until the transfer
    task automatic send(input in_item_t it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drain, let a result-free item finish, then write the target register
    task automatic set_target(input logic [6:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        target = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver: stall a random number of cycles before each result transfer
    initial
    begin
        int n;
        @(posedge rst_n);
        forever begin
            n = gaps_on ? $urandom_range(0, 18) : 0;
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        logic [6:0] phase_targets [6];
        int f, oth, ch;
        in_item_t it;
        phase_targets[0] = 7'd127;
        phase_targets[1] = 7'd0;
        phase_targets[2] = 7'd64;
        phase_targets[3] = 7'($urandom_range(1, 126));
        phase_targets[4] = 7'd1;
        phase_targets[5] = 7'($urandom_range(0, 127));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty solve gives identity, loaded gain comes back when singular
        send(make_item(FUNC_SOLVE, 0, 0, 0));
        send(make_item(FUNC_LOAD, 0, 2, 0));
        send(make_item(FUNC_SOLVE, 5, 2, 0));
        // Self baseline and unused function code leave the sums empty
        send(make_item(FUNC_ACC, 0, 3, 0));
        send(make_item(FUNC_NONE, 9, 3, 1));
        send(make_item(FUNC_SOLVE, 0, 3, 0));
        // Conjugate-transpose form, well conditioned and at the corners of the format
        send(make_item(FUNC_ACC, 9, 4, 0));
        send(make_item(FUNC_ACC, 10, 4, 0));
        send(make_item(FUNC_SOLVE, 0, 4, 0));
        send(make_item(FUNC_ACC, 127, 5, 2));
        send(make_item(FUNC_SOLVE, 0, 5, 0));
        send(make_item(FUNC_LOAD, 127, 31, 1));
        send(make_item(FUNC_ACC, 127, 31, 1));
        send(make_item(FUNC_SOLVE, 127, 31, 1));
        // Plain form against a lower partner, conjugate-transpose form against a higher one
        set_target(7'd100);
        send(make_item(FUNC_LOAD, 3, 6, 0));
        send(make_item(FUNC_ACC, 3, 6, 0));
        send(make_item(FUNC_ACC, 127, 6, 0));
        send(make_item(FUNC_ACC, 100, 6, 0));
        send(make_item(FUNC_SOLVE, 0, 6, 0));

        // Random phases of loads, accumulations and solves, mostly on channels 0 to 3
        for (int ph = 0; ph < 6; ph++) begin
            set_target(phase_targets[ph]);
            for (int i = 0; i < 75; i++) begin
                if (i % 25 == 0)
                    gaps_on = ($urandom_range(0, 3) != 0);
                f = $urandom_range(0, 99);
                ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
                oth = ($urandom_range(0, 9) == 0) ? int'(target) : $urandom_range(0, 127);
                if (f < 15)
                    it = make_item(FUNC_LOAD, oth, ch, pick_kind());
                else if (f < 75)
                    it = make_item(FUNC_ACC, oth, ch, pick_kind());
                else if (f < 95)
                    it = make_item(FUNC_SOLVE, oth, ch, pick_kind());
                else
                    it = make_item(FUNC_NONE, oth, ch, 1);
                send(it);
            end
        end
        in_valid <= 1'b0;

        // Drain and let the last item settle
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
